FILE: rtl/s2cd_pkg.sv
// Package for the seconds-to-civil-date converter: payload types, calendar
// constants and the fixed-point reciprocals used for the constant divisions.
// No dependencies; used by the datapath and the top level.
package s2cd_pkg;

	// Transaction payloads
	typedef struct packed {
		logic signed [39:0] epoch_seconds;
	} in_t;

	typedef struct packed {
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [5:0]         second;
		logic [2:0]         weekday;
		logic [8:0]         day_of_year;
		logic signed [15:0] years_since_1900;
		logic [3:0]         month_index;
		logic [4:0]         day_of_month;
	} out_t;

	// Register stages in the datapath
	localparam int NumStages = 12;

	// Calendar constants
	localparam longint SecPerDay     = 86400;
	localparam longint ShiftToMarch0 = 719468;
	localparam longint EraDays       = 146097;
	localparam longint CentDays      = 36524;
	localparam longint QuadDays      = 1461;
	localparam longint YearDays      = 365;
	localparam longint MonthSpan     = 153;
	localparam longint MarchToDec    = 306;
	localparam longint JanFebDays    = 59;
	localparam longint SecPerHour    = 3600;
	localparam longint SecPerMin     = 60;
	localparam longint WeekDays      = 7;
	localparam longint March0Wday    = 3;
	localparam longint DayDivOdd     = SecPerDay / 128;

	// Input bias: whole eras plus the March-0 shift, so the biased second count
	// is never negative and floor division becomes plain unsigned division.
	localparam longint EraBias  = 39;
	localparam longint DayBias  = ShiftToMarch0 + EraDays * EraBias;
	localparam logic [40:0] SecBias = 41'(SecPerDay * DayBias);
	localparam longint YearBias = 400 * EraBias + 1900;

	// Reciprocals ceil(2^(N+l)/d): exact quotient for any N-bit dividend
	localparam logic [34:0] RecipDay   = 35'(((64'd1 << 44) + 64'd674) / 64'd675);
	localparam logic [24:0] RecipEra   = 25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
	localparam logic [17:0] RecipHour  = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
	localparam logic [18:0] RecipQuad  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam logic [18:0] RecipWeek  = 19'(((64'd1 << 21) + 64'd6) / 64'd7);
	localparam logic [12:0] RecipMin   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
	localparam logic [18:0] RecipYear  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
	localparam logic [11:0] RecipMonth = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

	// First day-of-year (March based) of each month slot: (153*mp + 2) / 5
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/s2cd_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
// Depends on nothing; the payload type is supplied by the instantiating code.
interface s2cd_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/seconds_to_civil_date_time.sv
// Seconds since 1970 to broken-down UTC calendar time, one transaction per cycle.
// Path from input acceptance to rsp.valid: 12 datapath stages, then the output
// register. Throughput: one transaction per clock, limited by nothing but downstream
// ready; a two-entry output buffer absorbs a stall.
// Reset (arst_n low, asynchronous) empties the pipeline and the output buffer.
// Depends on s2cd_pkg, s2cd_chan_if and s2cd_datapath.
module seconds_to_civil_date_time (
	input  logic         clk,
	input  logic         arst_n,
	s2cd_chan_if.sink    req,
	s2cd_chan_if.source  rsp
);
	import s2cd_pkg::*;

	logic [NumStages-1:0] vld_q;
	logic                 en;
	logic                 push, pop;
	logic                 out_vld_q, skid_vld_q;
	out_t                 pipe_data;
	out_t                 out_q, skid_q;

	// Whole pipeline advances unless the skid entry is holding a result
	assign en        = ~skid_vld_q;
	assign req.ready = en;
	assign push      = en & vld_q[NumStages-1];
	assign pop       = out_vld_q & rsp.ready;

	s2cd_datapath u_dp (
		.clk      (clk),
		.en       (en),
		.in_data  (req.payload),
		.out_data (pipe_data)
	);

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NumStages-2:0], req.valid};
		end
	end

	// Output register plus skid entry: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output register plus skid entry: payload
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_q <= pipe_data;
			end else begin
				out_q <= pipe_data;
			end
		end
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.payload = out_q;

endmodule

FILE: rtl/s2cd_datapath.sv
// Twelve-stage arithmetic pipeline: seconds to time of day, day count, era,
// year of era, month and day. Payload registers only, all on one enable.
// Depends on s2cd_pkg.
module s2cd_datapath (
	input  logic           clk,
	input  logic           en,
	input  s2cd_pkg::in_t  in_data,
	output s2cd_pkg::out_t out_data
);
	import s2cd_pkg::*;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] weekday;
	} tod_t;

	// Stage registers
	logic [40:0] u_s1;
	logic [51:0] pplo_s2, pphi_s2;
	logic [33:0] t_s2, t_s3;
	logic [6:0]  lo7_s2, lo7_s3;
	logic [23:0] d_s3, d_s4, d_s5;
	logic [16:0] sod_s4, sod_s5;
	logic [6:0]  qe_s5, qe_s6, qe_s7, qe_s8, qe_s9, qe_s10, qe_s11;
	logic [4:0]  hr_s5, hr_s6, hr_s7, hr_s8;
	logic [17:0] doe_s6, doe_s7, doe_s8, doe_s9;
	logic [17:0] x_s6, x_s7;
	logic [11:0] msr_s6, msr_s7;
	logic [6:0]  n_s7;
	logic [2:0]  c_s7;
	logic [14:0] qw_s7;
	logic [5:0]  min_s7, min_s8;
	logic [17:0] v_s8;
	logic [2:0]  wd_s8;
	logic [5:0]  sec_s8;
	logic [8:0]  yoe_s9, yoe_s10, yoe_s11;
	tod_t        tod_s9, tod_s10, tod_s11;
	logic [8:0]  doy_s10, doy_s11;
	logic        leap_s10;
	logic [3:0]  mp_s11;
	logic [8:0]  yday_s11;
	out_t        out_s12;

	// Stage 2: split 34x35 reciprocal multiply into two partial products
	logic [33:0] t1;
	logic [51:0] pplo_c, pphi_c;
	assign t1     = u_s1[40:7];
	assign pplo_c = 52'(t1[16:0]) * 52'(RecipDay);
	assign pphi_c = 52'(t1[33:17]) * 52'(RecipDay);

	// Stage 3: combine partial products, day count = t / 675
	logic [68:0] dprod_c;
	assign dprod_c = {pphi_s2, 17'b0} + 69'(pplo_s2);

	// Stage 4: second of day from the remainder and the low seven bits
	logic [33:0] rem_c;
	assign rem_c = t_s3 - 34'(d_s3) * 34'(DayDivOdd);

	// Stage 5: era quotient and hour
	logic [48:0] eprod_c;
	logic [34:0] hprod_c;
	assign eprod_c = 49'(d_s4) * 49'(RecipEra);
	assign hprod_c = 35'(sod_s4) * 35'(RecipHour);

	// Stage 6: day of era, weekday operand, seconds within the hour
	logic [23:0] doe_c;
	logic [16:0] msr_c;
	assign doe_c = d_s5 - 24'(qe_s5) * 24'(EraDays);
	assign msr_c = sod_s5 - 17'(hr_s5) * 17'(SecPerHour);

	// Stage 7: leap-cycle corrections, weekday quotient, minute
	logic [36:0] qprod_c, wprod_c;
	logic [24:0] mprod_c;
	logic [2:0]  c_c;
	assign qprod_c = 37'(doe_s6) * 37'(RecipQuad);
	assign wprod_c = 37'(x_s6) * 37'(RecipWeek);
	assign mprod_c = 25'(msr_s6) * 25'(RecipMin);
	assign c_c = 3'(doe_s6 >= 18'(CentDays)) + 3'(doe_s6 >= 18'(CentDays * 2))
		+ 3'(doe_s6 >= 18'(CentDays * 3)) + 3'(doe_s6 >= 18'(CentDays * 4));

	// Stage 8: leap-adjusted day of era, weekday, second
	logic [17:0] v_c, wd_c;
	logic [11:0] sec_c;
	assign v_c = doe_s7 - 18'(n_s7) + 18'(c_s7) - 18'(doe_s7 >= 18'(EraDays - 1));
	assign wd_c = x_s7 - 18'(qw_s7) * 18'(WeekDays);
	assign sec_c = msr_s7 - 12'(min_s7) * 12'(SecPerMin);

	// Stage 9: year of era
	logic [36:0] yprod_c;
	assign yprod_c = 37'(v_s8) * 37'(RecipYear);

	// Stage 10: day of March-based year and leap flag
	logic [1:0]  cent_c;
	logic [17:0] doy_c;
	logic        leap_c;
	assign cent_c = 2'(yoe_s9 >= 9'd100) + 2'(yoe_s9 >= 9'd200) + 2'(yoe_s9 >= 9'd300);
	assign doy_c = doe_s9 - (18'(yoe_s9) * 18'(YearDays) + 18'(yoe_s9[8:2]) - 18'(cent_c));
	assign leap_c = (yoe_s9[1:0] == 2'd0)
		&& !(yoe_s9 == 9'd100 || yoe_s9 == 9'd200 || yoe_s9 == 9'd300);

	// Stage 11: month slot and January-based day of year
	logic [10:0] m5_c;
	logic [22:0] mpprod_c;
	logic [8:0]  yday_c;
	assign m5_c = 11'(doy_s10) * 11'd5 + 11'd2;
	assign mpprod_c = 23'(m5_c) * 23'(RecipMonth);
	always_comb begin
		if (doy_s10 >= 9'(MarchToDec)) begin
			yday_c = doy_s10 - 9'(MarchToDec);
		end else begin
			yday_c = doy_s10 + 9'(JanFebDays) + 9'(leap_s10);
		end
	end

	// Stage 12: month, day of month, year
	logic        jan_feb_c;
	logic [8:0]  dom_c;
	logic [3:0]  mon_c;
	logic [15:0] year_c;
	assign jan_feb_c = (mp_s11 >= 4'd10);
	assign dom_c = doy_s11 - month_start(mp_s11) + 9'd1;
	assign mon_c = jan_feb_c ? mp_s11 - 4'd10 : mp_s11 + 4'd2;
	assign year_c = 16'(yoe_s11) + 16'(qe_s11) * 16'd400 - 16'(YearBias) + 16'(jan_feb_c);

	// Pipeline registers
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= {in_data.epoch_seconds[39], in_data.epoch_seconds} + SecBias;

			pplo_s2 <= pplo_c;
			pphi_s2 <= pphi_c;
			t_s2    <= t1;
			lo7_s2  <= u_s1[6:0];

			d_s3   <= dprod_c[67:44];
			t_s3   <= t_s2;
			lo7_s3 <= lo7_s2;

			d_s4   <= d_s3;
			sod_s4 <= {rem_c[9:0], lo7_s3};

			d_s5   <= d_s4;
			sod_s5 <= sod_s4;
			qe_s5  <= eprod_c[48:42];
			hr_s5  <= hprod_c[33:29];

			doe_s6 <= doe_c[17:0];
			x_s6   <= doe_c[17:0] + 18'(March0Wday);
			msr_s6 <= msr_c[11:0];
			qe_s6  <= qe_s5;
			hr_s6  <= hr_s5;

			n_s7   <= qprod_c[35:29];
			c_s7   <= c_c;
			qw_s7  <= wprod_c[35:21];
			min_s7 <= mprod_c[23:18];
			doe_s7 <= doe_s6;
			x_s7   <= x_s6;
			msr_s7 <= msr_s6;
			qe_s7  <= qe_s6;
			hr_s7  <= hr_s6;

			v_s8   <= v_c;
			wd_s8  <= wd_c[2:0];
			sec_s8 <= sec_c[5:0];
			doe_s8 <= doe_s7;
			qe_s8  <= qe_s7;
			hr_s8  <= hr_s7;
			min_s8 <= min_s7;

			yoe_s9         <= yprod_c[35:27];
			doe_s9         <= doe_s8;
			qe_s9          <= qe_s8;
			tod_s9.hour    <= hr_s8;
			tod_s9.minute  <= min_s8;
			tod_s9.second  <= sec_s8;
			tod_s9.weekday <= wd_s8;

			doy_s10  <= doy_c[8:0];
			leap_s10 <= leap_c;
			yoe_s10  <= yoe_s9;
			qe_s10   <= qe_s9;
			tod_s10  <= tod_s9;

			mp_s11   <= mpprod_c[22:19];
			yday_s11 <= yday_c;
			doy_s11  <= doy_s10;
			yoe_s11  <= yoe_s10;
			qe_s11   <= qe_s10;
			tod_s11  <= tod_s10;

			out_s12.hour             <= tod_s11.hour;
			out_s12.minute           <= tod_s11.minute;
			out_s12.second           <= tod_s11.second;
			out_s12.weekday          <= tod_s11.weekday;
			out_s12.day_of_year      <= yday_s11;
			out_s12.years_since_1900 <= year_c;
			out_s12.month_index      <= mon_c;
			out_s12.day_of_month     <= dom_c[4:0];
		end
	end

	assign out_data = out_s12;

endmodule

FILE: test/seconds_to_civil_date_time_tb.sv
// Self-checking testbench for seconds_to_civil_date_time: directed calendar corners,
// then random timestamps, with random idling on both channels and one long output stall.
// Depends on s2cd_pkg, s2cd_chan_if and the seconds_to_civil_date_time top level.
`timescale 1ns / 100ps

module seconds_to_civil_date_time_tb;
	import s2cd_pkg::*;

	// Calendar constants for the predictor
	localparam longint DaySeconds  = 86400;
	localparam longint MarchShift  = 719468;
	localparam longint CycleDays   = 146097;
	localparam longint CenturyDays = 36524;
	localparam longint LeapGroup   = 1461;
	localparam longint CommonYear  = 365;
	localparam longint MarchWday   = 3;
	localparam longint MarToDec    = 306;
	localparam longint JanFeb      = 59;
	localparam longint MaxEpoch    = 64'sd549755813887;
	localparam longint MinEpoch    = -64'sd549755813888;

	// Run control
	localparam int     RandomCount = 1950;
	localparam int     StallAfter  = 500;
	localparam int     StallCycles = 300;
	localparam int     DrainCycles = 20;
	localparam longint TimeoutNs   = 4_000_000;

	localparam int NumDirected = 21;
	localparam longint DirectedTimes [NumDirected] = '{
		0,                  // epoch, Thursday
		-1,                 // last second of 1969
		3599,
		86399,
		86400,
		-86400,
		-86401,
		MaxEpoch,
		MinEpoch,
		951782400,          // 2000-02-29, leap century
		951868800,          // 2000-03-01
		978307199,          // 2000-12-31 23:59:59, day of year 365
		978307200,          // 2001-01-01
		64'sd4107542399,    // 2100-02-28 23:59:59, non-leap century
		64'sd4107542400,    // 2100-03-01
		2147483647,         // 32-bit rollover
		64'sd2147483648,
		-64'sd62162035200,  // 0000-03-01, start of an era
		-64'sd62162035201,  // 0000-02-29 23:59:59, previous era
		-64'sd2203891201,   // 1900-02-28 23:59:59
		64'sd253402300799   // 9999-12-31 23:59:59
	};

	// Scoreboard: predicts the calendar fields of each accepted timestamp and
	// checks results in order.
	class civil_time_scoreboard;
		out_t pending_dates [$];
		int   errors;
		int   accepted;

		function new();
			errors   = 0;
			accepted = 0;
		endfunction

		function out_t civil_from_seconds(logic [39:0] raw);
			longint secs, days, sod, wd, era, doe, yoe, doy, mp, dom, mon, year, yday;
			bit     leap;
			out_t   r;
			secs = $signed(raw);
			days = secs / DaySeconds;
			sod  = secs % DaySeconds;
			// floor toward the earlier day for negative times
			if (sod < 0) begin
				sod  += DaySeconds;
				days -= 1;
			end
			days += MarchShift;
			wd = (MarchWday + days) % 7;
			if (wd < 0)
				wd += 7;
			era  = (days >= 0 ? days : days - (CycleDays - 1)) / CycleDays;
			doe  = days - era * CycleDays;
			yoe  = (doe - doe / (LeapGroup - 1) + doe / CenturyDays
				- doe / (CycleDays - 1)) / CommonYear;
			doy  = doe - (CommonYear * yoe + yoe / 4 - yoe / 100);
			mp   = (5 * doy + 2) / 153;
			dom  = doy - (153 * mp + 2) / 5 + 1;
			mon  = mp < 10 ? mp + 2 : mp - 10;
			year = yoe + era * 400 + (mon <= 1 ? 1 : 0);
			leap = (yoe % 4 == 0) && ((yoe % 100 != 0) || (yoe % 400 == 0));
			// day of year counts from January; Jan/Feb sit at the end of the March year
			if (doy >= MarToDec)
				yday = doy - MarToDec;
			else
				yday = doy + JanFeb + (leap ? 1 : 0);
			r.hour             = 5'(sod / 3600);
			r.minute           = 6'((sod % 3600) / 60);
			r.second           = 6'(sod % 60);
			r.weekday          = 3'(wd);
			r.day_of_year      = 9'(yday);
			r.years_since_1900 = 16'(year - 1900);
			r.month_index      = 4'(mon);
			r.day_of_month     = 5'(dom);
			return r;
		endfunction

		function void note_request(logic [39:0] secs);
			pending_dates.push_back(civil_from_seconds(secs));
			accepted++;
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_response(out_t got);
			out_t want;
			if (pending_dates.size() == 0) begin
				$error("result transaction with no request outstanding");
				errors++;
				return;
			end
			want = pending_dates.pop_front();
			compare_field("hour", want.hour, got.hour);
			compare_field("minute", want.minute, got.minute);
			compare_field("second", want.second, got.second);
			compare_field("weekday", want.weekday, got.weekday);
			compare_field("day_of_year", want.day_of_year, got.day_of_year);
			compare_field("years_since_1900", $signed(want.years_since_1900),
				$signed(got.years_since_1900));
			compare_field("month_index", want.month_index, got.month_index);
			compare_field("day_of_month", want.day_of_month, got.day_of_month);
		endfunction

		function int pending();
			return pending_dates.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	s2cd_chan_if #(.payload_t(in_t))  req_if ();
	s2cd_chan_if #(.payload_t(out_t)) rsp_if ();

	seconds_to_civil_date_time uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	civil_time_scoreboard sb;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Random timestamp, biased toward day, era and range boundaries
	function automatic logic [39:0] draw_epoch();
		longint t;
		longint era;
		case ($urandom_range(7))
			0, 1, 2: t = $signed({8'($urandom), 32'($urandom)});
			3:       t = $signed(32'($urandom));
			4: begin
				t = (longint'($urandom_range(12_700_000)) - 6_350_000) * DaySeconds
					+ longint'($urandom_range(4)) - 2;
			end
			5: begin
				era = longint'($urandom_range(86)) - 43;
				t = (era * CycleDays - MarchShift + longint'($urandom_range(2)) - 1)
					* DaySeconds + longint'($urandom_range(86399));
			end
			6: begin
				if ($urandom_range(1))
					t = MaxEpoch - longint'($urandom_range(200000));
				else
					t = MinEpoch + longint'($urandom_range(200000));
			end
			default: t = longint'($urandom_range(200000)) - 100000;
		endcase
		return 40'(t);
	endfunction

	// Offer one request transaction after an idle gap; return once it is taken
	task automatic send_request(input logic [39:0] secs, input int gap);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.payload.epoch_seconds <= secs;
		do @(posedge clk); while (!req_if.ready);
		sb.note_request(secs);
	endtask

	// Accept results with random stalls, one long hold-off partway through
	task automatic drain_responses();
		int gap;
		int received;
		bit stalled;
		received = 0;
		stalled  = 1'b0;
		forever begin
			if (!stalled && sb.accepted >= StallAfter) begin
				stalled = 1'b1;
				gap = StallCycles;
			end else if ((received / 60) % 4 == 2) begin
				gap = 0;
			end else begin
				gap = $urandom_range(9);
			end
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			sb.check_response(rsp_if.payload);
			received++;
		end
	endtask

	// Main sequence
	initial begin
		int gap;
		sb = new();
		arst_n        <= 1'b0;
		req_if.valid  <= 1'b0;
		req_if.payload <= '0;
		rsp_if.ready  <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			drain_responses();
		join_none

		// directed corners
		for (int i = 0; i < NumDirected; i++)
			send_request(40'(DirectedTimes[i]), $urandom_range(9));

		// random timestamps, with back-to-back stretches
		for (int i = 0; i < RandomCount; i++) begin
			gap = ((i / 50) % 4 == 1) ? 0 : $urandom_range(9);
			send_request(draw_epoch(), gap);
		end
		req_if.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog
	initial begin
		#(TimeoutNs);
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
rtl/s2cd_pkg.sv
rtl/s2cd_chan_if.sv
rtl/s2cd_datapath.sv
rtl/seconds_to_civil_date_time.sv
test/seconds_to_civil_date_time_tb.sv
